[design/pcte_pkg.sv]
// pcte_pkg: shared types and constants for the path command to edge stream block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pcte_pkg;

    // fixed field widths of the channels
    localparam int REQ_W   = 3;
    localparam int KIND_W  = 3;
    localparam int FIELD_W = 32;

    // defaults handed to the top level parameters
    localparam int COORD_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // command codes on the request channel
    typedef enum logic [REQ_W-1:0] {
        REQ_MOVE  = 3'd0,
        REQ_LINE  = 3'd1,
        REQ_CURVE = 3'd2,
        REQ_CLOSE = 3'd3,
        REQ_END   = 3'd4
    } req_t;

    // result kinds on the output channel
    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE   = 3'd0,
        KIND_SPLINE = 3'd1,
        KIND_CAP    = 3'd2,
        KIND_JOIN   = 3'd3,
        KIND_PATH   = 3'd4
    } kind_t;

    // work passed from front to back, one entry per request that produces output
    typedef enum logic [2:0] {
        ACT_EDGE      = 3'd0,
        ACT_SPLINE    = 3'd1,
        ACT_CAP       = 3'd2,
        ACT_PATH      = 3'd3,
        ACT_CAP_PATH  = 3'd4,
        ACT_EDGE_JOIN = 3'd5
    } act_t;

    localparam int ACT_W = $bits(act_t);

    // coordinate slots of a queue entry, counted from the lsb
    localparam int SLOT_EY  = 0;
    localparam int SLOT_EX  = 1;
    localparam int SLOT_BY  = 2;
    localparam int SLOT_BX  = 3;
    localparam int SLOT_AY  = 4;
    localparam int SLOT_AX  = 5;
    localparam int SLOT_SY  = 6;
    localparam int SLOT_SX  = 7;
    localparam int NUM_SLOT = 8;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[design/pcte_front.sv]
// pcte_front: accepts path requests, keeps the pen state and classifies each request
// depends on pcte_pkg; pushes work entries into pcte_queue
`timescale 1ns / 1ps

module pcte_front import pcte_pkg::*; #(
    parameter int CW    = 32,
    parameter int ENT_W = ACT_W + NUM_SLOT * 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [REQ_W-1:0]          s_req_type,
    input  logic signed [FIELD_W-1:0] s_pa_x,
    input  logic signed [FIELD_W-1:0] s_pa_y,
    input  logic signed [FIELD_W-1:0] s_pb_x,
    input  logic signed [FIELD_W-1:0] s_pb_y,
    input  logic signed [FIELD_W-1:0] s_pc_x,
    input  logic signed [FIELD_W-1:0] s_pc_y,
    input  q_stat_t                   q_stat,
    output logic                      push,
    output logic [ENT_W-1:0]          push_data
);

    logic [CW-1:0] cur_x_reg, cur_y_reg, first_x_reg, first_y_reg;
    logic [CW-1:0] cur_x_next, cur_y_next, first_x_next, first_y_next;
    logic          have_point_reg, have_edge_reg;
    logic          have_point_next, have_edge_next;

    logic [CW-1:0] ax, ay, bx, by, cx, cy;
    logic          accept;
    logic          emit;
    act_t          act;
    logic [CW-1:0] sx, sy, ox, oy, px, py, ex, ey;

    assign ax = s_pa_x[CW-1:0];
    assign ay = s_pa_y[CW-1:0];
    assign bx = s_pb_x[CW-1:0];
    assign by = s_pb_y[CW-1:0];
    assign cx = s_pc_x[CW-1:0];
    assign cy = s_pc_y[CW-1:0];

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        have_point_next = have_point_reg;
        have_edge_next  = have_edge_reg;
        emit = 1'b0;
        act  = ACT_EDGE;
        sx = '0; sy = '0; ox = '0; oy = '0;
        px = '0; py = '0; ex = '0; ey = '0;
        case (req_t'(s_req_type))
            REQ_MOVE: begin
                emit            = have_edge_reg;
                act             = ACT_CAP;
                first_x_next    = ax;
                first_y_next    = ay;
                cur_x_next      = ax;
                cur_y_next      = ay;
                have_point_next = 1'b1;
                have_edge_next  = 1'b0;
            end
            REQ_LINE: begin
                if (have_point_reg) begin
                    emit           = 1'b1;
                    act            = ACT_EDGE;
                    sx = cur_x_reg; sy = cur_y_reg;
                    ex = ax;        ey = ay;
                    cur_x_next     = ax;
                    cur_y_next     = ay;
                    have_edge_next = 1'b1;
                end else begin
                    first_x_next    = ax;
                    first_y_next    = ay;
                    cur_x_next      = ax;
                    cur_y_next      = ay;
                    have_point_next = 1'b1;
                    have_edge_next  = 1'b0;
                end
            end
            REQ_CURVE: begin
                if (have_point_reg) begin
                    emit           = 1'b1;
                    act            = ACT_SPLINE;
                    sx = cur_x_reg; sy = cur_y_reg;
                    ox = ax; oy = ay;
                    px = bx; py = by;
                    ex = cx; ey = cy;
                    cur_x_next     = cx;
                    cur_y_next     = cy;
                    have_edge_next = 1'b1;
                end else begin
                    first_x_next    = cx;
                    first_y_next    = cy;
                    cur_x_next      = cx;
                    cur_y_next      = cy;
                    have_point_next = 1'b1;
                    have_edge_next  = 1'b0;
                end
            end
            REQ_CLOSE: begin
                emit = have_edge_reg;
                act  = ACT_EDGE_JOIN;
                sx = cur_x_reg;   sy = cur_y_reg;
                ex = first_x_reg; ey = first_y_reg;
                cur_x_next      = '0;
                cur_y_next      = '0;
                first_x_next    = '0;
                first_y_next    = '0;
                have_point_next = 1'b0;
                have_edge_next  = 1'b0;
            end
            REQ_END: begin
                emit = 1'b1;
                act  = have_edge_reg ? ACT_CAP_PATH : ACT_PATH;
                cur_x_next      = '0;
                cur_y_next      = '0;
                first_x_next    = '0;
                first_y_next    = '0;
                have_point_next = 1'b0;
                have_edge_next  = 1'b0;
            end
            default: begin
                // unknown code: no output, state kept
                emit = 1'b0;
            end
        endcase
    end

    assign push      = accept && emit;
    assign push_data = {act, sx, sy, ox, oy, px, py, ex, ey};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            have_point_reg <= 1'b0;
            have_edge_reg  <= 1'b0;
        end else if (accept) begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            have_point_reg <= have_point_next;
            have_edge_reg  <= have_edge_next;
        end
    end

endmodule

[design/pcte_queue.sv]
// pcte_queue: small register queue decoupling the request front from the output back
// depends on pcte_pkg for the status struct
`timescale 1ns / 1ps

module pcte_queue import pcte_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output q_stat_t          q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head_data    = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/pcte_back.sv]
// pcte_back: expands queued work into one or two results and holds the output register
// depends on pcte_pkg; drains pcte_queue
`timescale 1ns / 1ps

module pcte_back import pcte_pkg::*; #(
    parameter int CW    = 32,
    parameter int ENT_W = ACT_W + NUM_SLOT * 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  q_stat_t                   q_stat,
    input  logic [ENT_W-1:0]          head_data,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [KIND_W-1:0]         m_kind,
    output logic signed [FIELD_W-1:0] m_start_x,
    output logic signed [FIELD_W-1:0] m_start_y,
    output logic signed [FIELD_W-1:0] m_ctl_one_x,
    output logic signed [FIELD_W-1:0] m_ctl_one_y,
    output logic signed [FIELD_W-1:0] m_ctl_two_x,
    output logic signed [FIELD_W-1:0] m_ctl_two_y,
    output logic signed [FIELD_W-1:0] m_end_x,
    output logic signed [FIELD_W-1:0] m_end_y,
    output logic                      m_last
);

    act_t          act;
    logic          two_part;
    logic          is_final;
    logic          has_coords;
    kind_t         kind_next;
    logic          load;
    logic [CW-1:0] slot [NUM_SLOT];
    logic [CW-1:0] coord_next [NUM_SLOT];

    logic                      valid_reg;
    logic                      phase_reg;
    kind_t                     kind_reg;
    logic                      last_reg;
    logic [FIELD_W-1:0]        coord_reg [NUM_SLOT];

    assign act = act_t'(head_data[ENT_W-1 -: ACT_W]);

    for (genvar i = 0; i < NUM_SLOT; i++) begin : g_slot
        assign slot[i]       = head_data[i*CW +: CW];
        assign coord_next[i] = has_coords ? slot[i] : '0;
    end

    always_comb begin
        two_part   = 1'b0;
        has_coords = 1'b0;
        kind_next  = KIND_EDGE;
        case (act)
            ACT_EDGE: begin
                kind_next  = KIND_EDGE;
                has_coords = 1'b1;
            end
            ACT_SPLINE: begin
                kind_next  = KIND_SPLINE;
                has_coords = 1'b1;
            end
            ACT_CAP: begin
                kind_next = KIND_CAP;
            end
            ACT_PATH: begin
                kind_next = KIND_PATH;
            end
            ACT_CAP_PATH: begin
                two_part  = 1'b1;
                kind_next = phase_reg ? KIND_PATH : KIND_CAP;
            end
            ACT_EDGE_JOIN: begin
                two_part   = 1'b1;
                kind_next  = phase_reg ? KIND_JOIN : KIND_EDGE;
                has_coords = !phase_reg;
            end
            default: begin
                kind_next = KIND_PATH;
            end
        endcase
    end

    assign is_final = !two_part || phase_reg;
    assign load     = !q_stat.empty && (!valid_reg || m_ready);
    assign pop      = load && is_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                phase_reg <= !is_final;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            last_reg <= is_final;
            for (int i = 0; i < NUM_SLOT; i++) begin
                coord_reg[i] <= FIELD_W'(coord_next[i]);
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_kind      = kind_reg;
    assign m_last      = last_reg;
    assign m_start_x   = coord_reg[SLOT_SX];
    assign m_start_y   = coord_reg[SLOT_SY];
    assign m_ctl_one_x = coord_reg[SLOT_AX];
    assign m_ctl_one_y = coord_reg[SLOT_AY];
    assign m_ctl_two_x = coord_reg[SLOT_BX];
    assign m_ctl_two_y = coord_reg[SLOT_BY];
    assign m_end_x     = coord_reg[SLOT_EX];
    assign m_end_y     = coord_reg[SLOT_EY];

endmodule

[design/path_command_to_edge_stream_top.sv]
// a request's first result goes through the work queue and then into the output register
// throughput: one request per cycle while each gives one result and the queue is not full; a close after an edge
//   or an end after an edge gives two results and holds the output side for the second one
// the work queue between front and back sets how far the two sides may drift apart
// reset: synchronous, active low; clears pen state, queue pointers and output valid
// depends on pcte_pkg, pcte_front, pcte_queue, pcte_back
`timescale 1ns / 1ps

module path_command_to_edge_stream_top import pcte_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [REQ_W-1:0]          s_req_type,
    input  logic signed [FIELD_W-1:0] s_pa_x,
    input  logic signed [FIELD_W-1:0] s_pa_y,
    input  logic signed [FIELD_W-1:0] s_pb_x,
    input  logic signed [FIELD_W-1:0] s_pb_y,
    input  logic signed [FIELD_W-1:0] s_pc_x,
    input  logic signed [FIELD_W-1:0] s_pc_y,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [KIND_W-1:0]         m_kind,
    output logic signed [FIELD_W-1:0] m_start_x,
    output logic signed [FIELD_W-1:0] m_start_y,
    output logic signed [FIELD_W-1:0] m_ctl_one_x,
    output logic signed [FIELD_W-1:0] m_ctl_one_y,
    output logic signed [FIELD_W-1:0] m_ctl_two_x,
    output logic signed [FIELD_W-1:0] m_ctl_two_y,
    output logic signed [FIELD_W-1:0] m_end_x,
    output logic signed [FIELD_W-1:0] m_end_y,
    output logic                      m_last
);

    // coordinates are kept at the narrower of the carry width and the field width;
    // bits above the field width would only ever hold zero
    localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    // one queue entry: action code plus eight coordinate slots
    localparam int ENT_W = ACT_W + NUM_SLOT * CW;

    q_stat_t          q_stat;
    logic             push;
    logic [ENT_W-1:0] push_data;
    logic             pop;
    logic [ENT_W-1:0] head_data;

    // front: takes every request, updates the current and first point,
    // and turns a request into at most one work entry
    pcte_front #(
        .CW    (CW),
        .ENT_W (ENT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_pa_x     (s_pa_x),
        .s_pa_y     (s_pa_y),
        .s_pb_x     (s_pb_x),
        .s_pb_y     (s_pb_y),
        .s_pc_x     (s_pc_x),
        .s_pc_y     (s_pc_y),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    // work queue: lets the front keep taking requests while a result waits
    pcte_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    // back: expands two-part entries (cap then path done, closing edge then join)
    // and drives the registered result channel
    pcte_back #(
        .CW    (CW),
        .ENT_W (ENT_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_stat      (q_stat),
        .head_data   (head_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_start_x   (m_start_x),
        .m_start_y   (m_start_y),
        .m_ctl_one_x (m_ctl_one_x),
        .m_ctl_one_y (m_ctl_one_y),
        .m_ctl_two_x (m_ctl_two_x),
        .m_ctl_two_y (m_ctl_two_y),
        .m_end_x     (m_end_x),
        .m_end_y     (m_end_y),
        .m_last      (m_last)
    );

endmodule

[design/pcte_checker.sv]
// pcte_checker: port-level assertions for path_command_to_edge_stream_top
// depends on pcte_pkg; attached to the top level by the bind at the end of this file
`timescale 1ns / 1ps

module pcte_checker import pcte_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [KIND_W-1:0]         m_kind,
    input logic signed [FIELD_W-1:0] m_start_x,
    input logic signed [FIELD_W-1:0] m_start_y,
    input logic signed [FIELD_W-1:0] m_ctl_one_x,
    input logic signed [FIELD_W-1:0] m_ctl_one_y,
    input logic signed [FIELD_W-1:0] m_ctl_two_x,
    input logic signed [FIELD_W-1:0] m_ctl_two_y,
    input logic signed [FIELD_W-1:0] m_end_x,
    input logic signed [FIELD_W-1:0] m_end_y,
    input logic                      m_last
);

    // a stalled result holds its valid, kind, last, start_x and end_x
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last)
            && $stable(m_start_x) && $stable(m_end_x))
        else $error("stalled result changed");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // marks carry no coordinates
    a_mark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_CAP || m_kind == KIND_JOIN || m_kind == KIND_PATH)
            |-> m_start_x == 0 && m_start_y == 0 && m_end_x == 0 && m_end_y == 0
                && m_ctl_one_x == 0 && m_ctl_one_y == 0
                && m_ctl_two_x == 0 && m_ctl_two_y == 0)
        else $error("mark with coordinates");

    // a straight edge has no control points
    a_edge_ctl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_EDGE
            |-> m_ctl_one_x == 0 && m_ctl_one_y == 0 && m_ctl_two_x == 0 && m_ctl_two_y == 0)
        else $error("edge with control points");

    // join, path done and spline always close their request; a cap before path done does not
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_JOIN || m_kind == KIND_PATH || m_kind == KIND_SPLINE)
            |-> m_last)
        else $error("last missing");

endmodule

bind path_command_to_edge_stream_top pcte_checker u_pcte_checker (.*);

[tb/sv/tb_path_command_to_edge_stream_top.sv]
// tb_path_command_to_edge_stream_top: self-checking bench for the path command to edge stream block
// predicts edge, spline, cap, join and path-done results from each accepted request
// depends on pcte_pkg and path_command_to_edge_stream_top
`timescale 1ns / 1ps

module tb_path_command_to_edge_stream_top;
    import pcte_pkg::*;

    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] COORD_NEG1 = 32'hffff_ffff;
    localparam int RANDOM_ITEMS = 1500;

    // unknown command codes, which the block ignores
    localparam logic [REQ_W-1:0] REQ_BAD_FIVE  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_BAD_SIX   = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_SEVEN = 3'd7;

    // coordinate slots of one result, in output port order
    localparam int C_START_X = 0;
    localparam int C_START_Y = 1;
    localparam int C_CTL1_X  = 2;
    localparam int C_CTL1_Y  = 3;
    localparam int C_CTL2_X  = 4;
    localparam int C_CTL2_Y  = 5;
    localparam int C_END_X   = 6;
    localparam int C_END_Y   = 7;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] coord [8];
        logic               last;
    } stroke_item_t;

    string coord_names [8] = '{"start_x", "start_y", "ctl_one_x", "ctl_one_y",
                               "ctl_two_x", "ctl_two_y", "end_x", "end_y"};

    // clock, reset and block ports; every input starts at a known value
    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type = REQ_MOVE;
    logic signed [FIELD_W-1:0] s_pa_x = '0;
    logic signed [FIELD_W-1:0] s_pa_y = '0;
    logic signed [FIELD_W-1:0] s_pb_x = '0;
    logic signed [FIELD_W-1:0] s_pb_y = '0;
    logic signed [FIELD_W-1:0] s_pc_x = '0;
    logic signed [FIELD_W-1:0] s_pc_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [KIND_W-1:0]         m_kind;
    logic signed [FIELD_W-1:0] m_start_x;
    logic signed [FIELD_W-1:0] m_start_y;
    logic signed [FIELD_W-1:0] m_ctl_one_x;
    logic signed [FIELD_W-1:0] m_ctl_one_y;
    logic signed [FIELD_W-1:0] m_ctl_two_x;
    logic signed [FIELD_W-1:0] m_ctl_two_y;
    logic signed [FIELD_W-1:0] m_end_x;
    logic signed [FIELD_W-1:0] m_end_y;
    logic                      m_last;

    // pen state of the predictor
    logic [FIELD_W-1:0] pen_x, pen_y, sub_x, sub_y;
    logic               pen_down, drew_edge;

    stroke_item_t pending_strokes [$];
    int           mismatch_count = 0;
    int           command_count = 0;
    int           burst_left = 0;

    // receiver stall pattern
    int stall_mode = 0;
    int stall_left = 0;

    always #1 aclk = ~aclk;

    path_command_to_edge_stream_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_pa_x      (s_pa_x),
        .s_pa_y      (s_pa_y),
        .s_pb_x      (s_pb_x),
        .s_pb_y      (s_pb_y),
        .s_pc_x      (s_pc_x),
        .s_pc_y      (s_pc_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_start_x   (m_start_x),
        .m_start_y   (m_start_y),
        .m_ctl_one_x (m_ctl_one_x),
        .m_ctl_one_y (m_ctl_one_y),
        .m_ctl_two_x (m_ctl_two_x),
        .m_ctl_two_y (m_ctl_two_y),
        .m_end_x     (m_end_x),
        .m_end_y     (m_end_y),
        .m_last      (m_last)
    );

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // a result with every coordinate zero; drawing results fill theirs in afterwards
    function automatic stroke_item_t blank_stroke(kind_t k);
        stroke_item_t r;
        r.kind = k;
        foreach (r.coord[i]) r.coord[i] = '0;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void lift_pen();
        pen_x = '0;
        pen_y = '0;
        sub_x = '0;
        sub_y = '0;
        pen_down = 1'b0;
        drew_edge = 1'b0;
    endfunction

    // new subpath: first point and current point both land on (x, y)
    function automatic void place_pen(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y);
        sub_x = x;
        sub_y = y;
        pen_x = x;
        pen_y = y;
        pen_down = 1'b1;
        drew_edge = 1'b0;
    endfunction

    // works out the results of one accepted request and queues them in order
    task automatic predict_strokes(logic [REQ_W-1:0] op,
                                   logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                                   logic [FIELD_W-1:0] bx, logic [FIELD_W-1:0] by,
                                   logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy);
        stroke_item_t out [$];
        stroke_item_t r;
        case (op)
            REQ_MOVE: begin
                if (drew_edge) out.push_back(blank_stroke(KIND_CAP));
                place_pen(ax, ay);
            end
            REQ_LINE: begin
                if (pen_down) begin
                    r = blank_stroke(KIND_EDGE);
                    r.coord[C_START_X] = pen_x;
                    r.coord[C_START_Y] = pen_y;
                    r.coord[C_END_X] = ax;
                    r.coord[C_END_Y] = ay;
                    out.push_back(r);
                    pen_x = ax;
                    pen_y = ay;
                    drew_edge = 1'b1;
                end else begin
                    place_pen(ax, ay);
                end
            end
            REQ_CURVE: begin
                if (pen_down) begin
                    r = blank_stroke(KIND_SPLINE);
                    r.coord[C_START_X] = pen_x;
                    r.coord[C_START_Y] = pen_y;
                    r.coord[C_CTL1_X] = ax;
                    r.coord[C_CTL1_Y] = ay;
                    r.coord[C_CTL2_X] = bx;
                    r.coord[C_CTL2_Y] = by;
                    r.coord[C_END_X] = cx;
                    r.coord[C_END_Y] = cy;
                    out.push_back(r);
                    pen_x = cx;
                    pen_y = cy;
                    drew_edge = 1'b1;
                end else begin
                    place_pen(cx, cy);
                end
            end
            REQ_CLOSE: begin
                // closing edge back to the subpath start, then the join mark
                if (drew_edge) begin
                    r = blank_stroke(KIND_EDGE);
                    r.coord[C_START_X] = pen_x;
                    r.coord[C_START_Y] = pen_y;
                    r.coord[C_END_X] = sub_x;
                    r.coord[C_END_Y] = sub_y;
                    out.push_back(r);
                    out.push_back(blank_stroke(KIND_JOIN));
                end
                lift_pen();
            end
            REQ_END: begin
                if (drew_edge) out.push_back(blank_stroke(KIND_CAP));
                out.push_back(blank_stroke(KIND_PATH));
                lift_pen();
            end
            default: ;
        endcase
        if (out.size() > 0) out[out.size() - 1].last = 1'b1;
        foreach (out[i]) pending_strokes.push_back(out[i]);
    endtask

    // sends one request; bursts of random length are separated by random gaps
    task automatic send_request(logic [REQ_W-1:0] op,
                                logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                                logic [FIELD_W-1:0] bx, logic [FIELD_W-1:0] by,
                                logic [FIELD_W-1:0] cx, logic [FIELD_W-1:0] cy);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_req_type <= op;
        s_pa_x <= ax;
        s_pa_y <= ay;
        s_pb_x <= bx;
        s_pb_y <= by;
        s_pc_x <= cx;
        s_pc_y <= cy;
        do @(posedge aclk); while (!s_ready);
        predict_strokes(op, ax, ay, bx, by, cx, cy);
        if (op <= REQ_END) command_count++;
    endtask

    // coordinates lean towards the extremes and whole-pixel values
    function automatic logic [FIELD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return COORD_NEG1;
            4: return {16'($urandom_range(0, 65535)), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(logic [REQ_W-1:0] op);
        send_request(op, pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord());
    endtask

    // holds the request channel idle until every predicted result has arrived
    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_strokes.size() != 0);
    endtask

    // draws with no current point, closes and ends with and without edges,
    // caps on move, and the unknown command codes
    task automatic test_special_cases();
        send_request(REQ_LINE, 32'h0001_0000, 32'h0002_0000, '0, '0, '0, '0);
        send_request(REQ_LINE, 32'h0003_0000, 32'h0004_0000, '0, '0, '0, '0);
        send_request(REQ_CLOSE, 32'h1234_5678, 32'h0, '0, '0, '0, '0);
        send_request(REQ_CURVE, 32'h1, 32'h2, 32'h3, 32'h4, 32'h0005_0000, 32'h0006_0000);
        send_request(REQ_CURVE, 32'h0007_0000, 32'h0008_0000, 32'h0009_0000,
                     32'h000a_0000, 32'h000b_0000, 32'h000c_0000);
        send_request(REQ_END, '0, '0, '0, '0, '0, '0);
        send_request(REQ_CLOSE, '0, '0, '0, '0, '0, '0);
        send_request(REQ_MOVE, 32'h0010_0000, 32'h0020_0000, '0, '0, '0, '0);
        send_request(REQ_CLOSE, '0, '0, '0, '0, '0, '0);
        send_request(REQ_END, '0, '0, '0, '0, '0, '0);
        send_request(REQ_MOVE, 32'h0001_8000, 32'h0002_8000, '0, '0, '0, '0);
        send_request(REQ_LINE, 32'h0003_8000, 32'h0004_8000, '0, '0, '0, '0);
        send_request(REQ_MOVE, 32'h0005_8000, 32'h0006_8000, '0, '0, '0, '0);
        send_request(REQ_BAD_FIVE, 32'h0bad_0000, '0, '0, '0, '0, '0);
        send_request(REQ_LINE, 32'h0007_8000, 32'h0008_8000, '0, '0, '0, '0);
        send_request(REQ_BAD_SIX, '0, 32'h0bad_0000, '0, '0, '0, '0);
        send_request(REQ_BAD_SEVEN, COORD_NEG1, COORD_NEG1, COORD_NEG1,
                     COORD_NEG1, COORD_NEG1, COORD_NEG1);
        send_request(REQ_END, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_extreme_coordinates();
        send_request(REQ_MOVE, COORD_MIN, COORD_MAX, '0, '0, '0, '0);
        send_request(REQ_LINE, COORD_MAX, COORD_MIN, '0, '0, '0, '0);
        send_request(REQ_CURVE, COORD_NEG1, '0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_request(REQ_LINE, '0, COORD_NEG1, '0, '0, '0, '0);
        send_request(REQ_CLOSE, COORD_MAX, COORD_MAX, '0, '0, '0, '0);
    endtask

    // stop sending after a two-result close, and again after a two-result end, and let the pipeline empty out
    task automatic test_drain_pause();
        send_random(REQ_MOVE);
        send_random(REQ_CURVE);
        send_random(REQ_CLOSE);
        wait_drained();
        send_random(REQ_MOVE);
        send_random(REQ_LINE);
        send_random(REQ_END);
        wait_drained();
    endtask

    // mostly well-formed paths with random content; some subpaths start
    // without a move, and a share of requests is pure noise
    task automatic test_random_paths(int n_items);
        int stop_at;
        int n_sub;
        int n_draw;
        stop_at = command_count + n_items;
        while (command_count < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                n_sub = $urandom_range(1, 3);
                for (int s = 0; s < n_sub; s++) begin
                    if ($urandom_range(0, 5) != 0) send_random(REQ_MOVE);
                    n_draw = $urandom_range(0, 5);
                    for (int d = 0; d < n_draw; d++)
                        send_random($urandom_range(0, 1) ? REQ_CURVE : REQ_LINE);
                    if ($urandom_range(0, 2) == 0) send_random(REQ_CLOSE);
                end
                if ($urandom_range(0, 9) != 0) send_random(REQ_END);
            end else begin
                repeat ($urandom_range(1, 4)) send_random(REQ_W'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 40) == 0) wait_drained();
        end
    endtask

    // result checker plus the receiver's own stall pattern
    always @(posedge aclk) begin
        stroke_item_t want;
        logic [FIELD_W-1:0] got_coord [8];
        if (aresetn && m_valid && m_ready) begin
            got_coord = '{m_start_x, m_start_y, m_ctl_one_x, m_ctl_one_y,
                          m_ctl_two_x, m_ctl_two_y, m_end_x, m_end_y};
            if (pending_strokes.size() == 0) begin
                report_mismatch($sformatf("unexpected result of kind %0d", m_kind));
            end else begin
                want = pending_strokes.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch($sformatf("kind got %0d want %0d", m_kind, want.kind));
                foreach (got_coord[i])
                    if (got_coord[i] !== want.coord[i])
                        report_mismatch($sformatf("%s got %h want %h (kind %0d)",
                                        coord_names[i], got_coord[i], want.coord[i],
                                        want.kind));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last got %b want %b (kind %0d)",
                                    m_last, want.last, want.kind));
            end
        end
        // modes: always ready, coin toss, long stalls
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        lift_pen();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_extreme_coordinates();
        test_drain_pause();
        test_random_paths(RANDOM_ITEMS);
        wait_drained();
        // grace period for any stray result
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_path_command_to_edge_stream_top OK");
        end else begin
            $display("tb_path_command_to_edge_stream_top NOT OK");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("tb_path_command_to_edge_stream_top NOT OK");
        $finish;
    end

endmodule

[path_command_to_edge_stream_top.f]
design/pcte_pkg.sv
design/pcte_front.sv
design/pcte_queue.sv
design/pcte_back.sv
design/path_command_to_edge_stream_top.sv
design/pcte_checker.sv
tb/sv/tb_path_command_to_edge_stream_top.sv
